FILE: rtl/core/prs_pkg.sv
// Shared types and constants for the page record store.
`timescale 1ns / 1ps
package prs_pkg;

	localparam int REC_HDR_BYTES = 7;

	typedef enum logic [2:0] {
		KIND_INIT   = 3'd0,
		KIND_APPEND = 3'd1,
		KIND_DATA   = 3'd2,
		KIND_FIND   = 3'd3,
		KIND_TOMB   = 3'd4,
		KIND_READ   = 3'd5
	} prs_kind_t;

	typedef enum logic [2:0] {
		STAT_APPENDED  = 3'd0,
		STAT_NO_ROOM   = 3'd1,
		STAT_FOUND     = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_MARKED    = 3'd4,
		STAT_NOT_MARK  = 3'd5,
		STAT_READ      = 3'd6,
		STAT_INIT      = 3'd7
	} prs_status_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_APPEND,
		MODE_FIND,
		MODE_TOMB
	} prs_mode_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HDR,
		S_RD,
		S_W_CHK,
		S_W_HDR,
		S_W_LEN,
		S_W_CMP
	} prs_state_t;

endpackage

FILE: rtl/core/prs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module prs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/page_record_store_top.sv
// Page record store: append-only record page with find, tombstone and read.
// Start append writes the record header one byte a cycle, and a read waits in S_RD for
// the registered page RAM data. An item that gives a result then stalls the input until
// the result is taken.
// Walks read each record header and compare the key only for live records of equal key length.
// Init and reset sweep the page RAM with input stalled; reset clears control.
`timescale 1ns / 1ps
module page_record_store_top
	import prs_pkg::*;
#(
	parameter int PAGE_BYTES   = 4096,
	parameter int HEADER_BYTES = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [15:0] key_len,
	input  logic [31:0] value_len,
	input  logic [7:0]  data_byte,
	input  logic [11:0] read_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [11:0] value_offset,
	output logic [11:0] value_length,
	output logic [7:0]  read_data,
	output logic [15:0] record_count,
	output logic [12:0] free_bytes
);
	localparam int AW = $clog2(PAGE_BYTES);
	localparam int PW = $clog2(PAGE_BYTES + 1);

	prs_state_t state_q, state_d;
	prs_mode_t  mode_q, mode_d;
	logic [15:0]   held_q, held_d;
	logic [PW-1:0] used_q, used_d;
	logic [15:0]   klen_q, klen_d;
	logic [31:0]   vlen_q, vlen_d;
	logic [15:0]   taken_q, taken_d;
	logic [2:0]    hb_q, hb_d;
	logic [PW-1:0] off_q, off_d;
	logic [PW-1:0] rec_end_q, rec_end_d;
	logic [15:0]   idx_q, idx_d;
	logic          flag_q, flag_d;
	logic [15:0]   ksz_q, ksz_d;
	logic [31:0]   vsz_q, vsz_d;
	logic [15:0]   j_q, j_d;
	logic [AW-1:0] clr_q, clr_d;
	logic          init_q, init_d;

	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [11:0]   voff_q, vlen_out_q;
	logic [7:0]    rd_q;
	logic [15:0]   count_q;
	logic [12:0]   free_q;

	logic          emit;
	prs_status_t   e_status;
	logic [11:0]   e_voff, e_vlen;
	logic [7:0]    e_rd;

	logic          pg_we, ky_we;
	logic [AW-1:0] pg_waddr, pg_raddr, ky_waddr, ky_raddr;
	logic [7:0]    pg_wdata, pg_rdata, ky_wdata, ky_rdata;

	logic          accept;
	logic [33:0]   need;
	logic [33:0]   rec_sum;
	logic [17:0]   taken_inc;
	logic [17:0]   app_total;
	logic [PW-1:0] app_end;

	prs_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_page (
		.clk   (clk),
		.we    (pg_we),
		.waddr (pg_waddr),
		.wdata (pg_wdata),
		.raddr (pg_raddr),
		.rdata (pg_rdata)
	);

	prs_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_key (
		.clk   (clk),
		.we    (ky_we),
		.waddr (ky_waddr),
		.wdata (ky_wdata),
		.raddr (ky_raddr),
		.rdata (ky_rdata)
	);

	assign in_stall = (state_q != S_IDLE) || out_valid_q;
	assign accept   = in_valid && !in_stall;

	assign need = 34'(REC_HDR_BYTES) + 34'(key_len) + 34'(value_len) + 34'(used_q);
	assign rec_sum = 34'(off_q) + 34'(REC_HDR_BYTES) + 34'(ksz_q) + 34'(vsz_q);
	assign taken_inc = 18'(taken_q) + 18'd1;
	assign app_total = 18'(klen_q) + 18'(vlen_q[PW-1:0]);
	assign app_end = used_q + PW'(REC_HDR_BYTES) + PW'(klen_q) + vlen_q[PW-1:0];

	always_comb begin
		state_d   = state_q;
		mode_d    = mode_q;
		held_d    = held_q;
		used_d    = used_q;
		klen_d    = klen_q;
		vlen_d    = vlen_q;
		taken_d   = taken_q;
		hb_d      = hb_q;
		off_d     = off_q;
		rec_end_d = rec_end_q;
		idx_d     = idx_q;
		flag_d    = flag_q;
		ksz_d     = ksz_q;
		vsz_d     = vsz_q;
		j_d       = j_q;
		clr_d     = clr_q;
		init_d    = init_q;
		emit      = 1'b0;
		e_status  = STAT_READ;
		e_voff    = '0;
		e_vlen    = '0;
		e_rd      = '0;
		pg_we     = 1'b0;
		pg_waddr  = '0;
		pg_wdata  = '0;
		pg_raddr  = '0;
		ky_we     = 1'b0;
		ky_waddr  = AW'(taken_q);
		ky_wdata  = data_byte;
		ky_raddr  = '0;

		unique case (state_q)
			S_CLEAR: begin
				pg_we    = 1'b1;
				pg_waddr = clr_q;
				clr_d    = clr_q + AW'(1);
				if (clr_q == AW'(PAGE_BYTES - 1)) begin
					state_d = S_IDLE;
					init_d  = 1'b0;
					if (init_q) begin
						emit     = 1'b1;
						e_status = STAT_INIT;
					end
				end
			end
			S_IDLE: begin
				if (accept) begin
					unique case (kind) inside
						KIND_INIT: begin
							mode_d  = MODE_IDLE;
							held_d  = '0;
							used_d  = PW'(HEADER_BYTES);
							taken_d = '0;
							clr_d   = '0;
							init_d  = 1'b1;
							state_d = S_CLEAR;
						end
						KIND_APPEND: begin
							mode_d = MODE_IDLE;
							if (need > 34'(PAGE_BYTES)) begin
								emit     = 1'b1;
								e_status = STAT_NO_ROOM;
							end else begin
								klen_d  = key_len;
								vlen_d  = value_len;
								taken_d = '0;
								hb_d    = '0;
								state_d = S_HDR;
							end
						end
						KIND_DATA: begin
							if (mode_q == MODE_APPEND) begin
								pg_we    = 1'b1;
								pg_waddr = AW'(used_q + PW'(REC_HDR_BYTES) + PW'(taken_q));
								pg_wdata = data_byte;
								taken_d  = taken_inc[15:0];
								if (taken_inc >= app_total) begin
									used_d   = app_end;
									held_d   = held_q + 16'd1;
									mode_d   = MODE_IDLE;
									emit     = 1'b1;
									e_status = STAT_APPENDED;
								end
							end else if (mode_q == MODE_FIND || mode_q == MODE_TOMB) begin
								ky_we   = 18'(taken_q) < 18'(PAGE_BYTES);
								taken_d = taken_inc[15:0];
								if (taken_inc >= 18'(klen_q)) begin
									off_d   = PW'(HEADER_BYTES);
									idx_d   = '0;
									state_d = S_W_CHK;
								end
							end
						end
						KIND_FIND, KIND_TOMB: begin
							mode_d  = (kind == KIND_FIND) ? MODE_FIND : MODE_TOMB;
							klen_d  = key_len;
							vlen_d  = '0;
							taken_d = '0;
							if (key_len == 16'd0) begin
								off_d   = PW'(HEADER_BYTES);
								idx_d   = '0;
								state_d = S_W_CHK;
							end
						end
						KIND_READ: begin
							if (18'(read_address) < 18'(PAGE_BYTES)) begin
								pg_raddr = AW'(read_address);
								state_d  = S_RD;
							end else begin
								emit     = 1'b1;
								e_status = STAT_READ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_HDR: begin
				pg_we    = 1'b1;
				pg_waddr = AW'(used_q + PW'(hb_q));
				case (hb_q)
					3'd0:    pg_wdata = 8'h00;
					3'd1:    pg_wdata = klen_q[7:0];
					3'd2:    pg_wdata = klen_q[15:8];
					3'd3:    pg_wdata = vlen_q[7:0];
					3'd4:    pg_wdata = vlen_q[15:8];
					3'd5:    pg_wdata = vlen_q[23:16];
					default: pg_wdata = vlen_q[31:24];
				endcase
				hb_d = hb_q + 3'd1;
				if (hb_q == 3'(REC_HDR_BYTES - 1)) begin
					state_d = S_IDLE;
					if (klen_q == 16'd0 && vlen_q == 32'd0) begin
						used_d   = app_end;
						held_d   = held_q + 16'd1;
						mode_d   = MODE_IDLE;
						emit     = 1'b1;
						e_status = STAT_APPENDED;
					end else begin
						mode_d = MODE_APPEND;
					end
				end
			end
			S_RD: begin
				emit     = 1'b1;
				e_status = STAT_READ;
				e_rd     = pg_rdata;
				state_d  = S_IDLE;
			end
			S_W_CHK: begin
				hb_d = '0;
				if (idx_q == held_q ||
				    18'(off_q) + 18'(REC_HDR_BYTES) > 18'(used_q)) begin
					emit     = 1'b1;
					e_status = (mode_q == MODE_TOMB) ? STAT_NOT_MARK : STAT_NOT_FOUND;
					mode_d   = MODE_IDLE;
					state_d  = S_IDLE;
				end else begin
					state_d = S_W_HDR;
				end
			end
			S_W_HDR: begin
				pg_raddr = AW'(off_q + PW'(hb_q));
				hb_d     = hb_q + 3'd1;
				case (hb_q)
					3'd1:    flag_d = pg_rdata[0];
					3'd2:    ksz_d[7:0]   = pg_rdata;
					3'd3:    ksz_d[15:8]  = pg_rdata;
					3'd4:    vsz_d[7:0]   = pg_rdata;
					3'd5:    vsz_d[15:8]  = pg_rdata;
					3'd6:    vsz_d[23:16] = pg_rdata;
					3'd7:    vsz_d[31:24] = pg_rdata;
					default: begin
					end
				endcase
				if (hb_q == 3'd7) begin
					state_d = S_W_LEN;
				end
			end
			S_W_LEN: begin
				j_d = '0;
				if (rec_sum > 34'(used_q)) begin
					emit     = 1'b1;
					e_status = (mode_q == MODE_TOMB) ? STAT_NOT_MARK : STAT_NOT_FOUND;
					mode_d   = MODE_IDLE;
					state_d  = S_IDLE;
				end else begin
					rec_end_d = rec_sum[PW-1:0];
					if (!flag_q && ksz_q == klen_q) begin
						state_d = S_W_CMP;
					end else begin
						off_d   = rec_sum[PW-1:0];
						idx_d   = idx_q + 16'd1;
						state_d = S_W_CHK;
					end
				end
			end
			S_W_CMP: begin
				pg_raddr = AW'(off_q + PW'(REC_HDR_BYTES) + PW'(j_q));
				ky_raddr = AW'(j_q);
				if (j_q != 16'd0 && pg_rdata != ky_rdata) begin
					off_d   = rec_end_q;
					idx_d   = idx_q + 16'd1;
					state_d = S_W_CHK;
				end else if (j_q == ksz_q) begin
					emit    = 1'b1;
					mode_d  = MODE_IDLE;
					state_d = S_IDLE;
					if (mode_q == MODE_TOMB) begin
						pg_we    = 1'b1;
						pg_waddr = AW'(off_q);
						pg_wdata = 8'h01;
						e_status = STAT_MARKED;
					end else begin
						e_status = STAT_FOUND;
						e_voff   = 12'(off_q + PW'(REC_HDR_BYTES) + PW'(ksz_q));
						e_vlen   = vsz_q[11:0];
					end
				end else begin
					j_d = j_q + 16'd1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			mode_q      <= MODE_IDLE;
			held_q      <= '0;
			used_q      <= PW'(HEADER_BYTES);
			klen_q      <= '0;
			taken_q     <= '0;
			clr_q       <= '0;
			init_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			held_q  <= held_d;
			used_q  <= used_d;
			klen_q  <= klen_d;
			taken_q <= taken_d;
			clr_q   <= clr_d;
			init_q  <= init_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		vlen_q    <= vlen_d;
		hb_q      <= hb_d;
		off_q     <= off_d;
		rec_end_q <= rec_end_d;
		idx_q     <= idx_d;
		flag_q    <= flag_d;
		ksz_q     <= ksz_d;
		vsz_q     <= vsz_d;
		j_q       <= j_d;
		if (emit) begin
			status_q   <= e_status;
			voff_q     <= e_voff;
			vlen_out_q <= e_vlen;
			rd_q       <= e_rd;
			count_q    <= held_d;
			free_q     <= 13'(PW'(PAGE_BYTES) - used_d);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign value_offset = voff_q;
	assign value_length = vlen_out_q;
	assign read_data    = rd_q;
	assign record_count = count_q;
	assign free_bytes   = free_q;
endmodule
